@@ hdl/lts_pkg.sv @@
// Shared types and constants for the light tracker servo step block.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package lts_pkg;

   // Sample width, pulse width and register-file geometry
   localparam int unsigned SampleWidth = 10;
   localparam int unsigned StepWidth   = 9;
   localparam int unsigned PulseWidth  = 15;
   localparam int unsigned AddrWidth   = 4;
   localparam int unsigned DataWidth   = 32;

   // Reset values of state and registers
   localparam logic [PulseWidth-1:0]  PulseReset   = 15'd1600;
   localparam logic [PulseWidth-1:0]  PulseTop     = 15'd32767;
   localparam logic [SampleWidth-1:0] MarginReset  = 10'd50;
   localparam logic [StepWidth-1:0]   StepReset    = 9'd25;
   localparam logic [PulseWidth-1:0]  PulseMinReset = 15'd600;
   localparam logic [PulseWidth-1:0]  PulseMaxReset = 15'd2600;

   // Divide by three: x / 3 == (x * 2731) >> 13 for x below 3072
   localparam logic [11:0] RecipThree = 12'd2731;
   localparam int unsigned RecipShift = 13;

   // Register indexes (word address)
   typedef enum logic [1:0] {
      REG_BRIGHT_MARGIN = 2'd0,
      REG_TURN_STEP     = 2'd1,
      REG_PULSE_MIN     = 2'd2,
      REG_PULSE_MAX     = 2'd3
   } reg_index_type;

   // Requested turn
   typedef enum logic [1:0] {
      TURN_NONE  = 2'd0,
      TURN_LEFT  = 2'd1,
      TURN_RIGHT = 2'd2
   } turn_type;

   // One set of sensor samples
   typedef struct packed {
      logic [SampleWidth-1:0] left_top;
      logic [SampleWidth-1:0] left_bottom;
      logic [SampleWidth-1:0] right_top;
      logic [SampleWidth-1:0] right_bottom;
   } sample_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [SampleWidth-1:0] bright_margin;
      logic [StepWidth-1:0]   turn_step;
      logic [PulseWidth-1:0]  pulse_min;
      logic [PulseWidth-1:0]  pulse_max;
   } cfg_type;

endpackage : lts_pkg

`default_nettype wire

@@ hdl/lts_csr.sv @@
// APB-style register file holding margin, turn step and pulse limits.
// Depends on lts_pkg for register indexes and the configuration struct.
`default_nettype none

module lts_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [lts_pkg::AddrWidth-1:0] paddr,
   input  wire logic [lts_pkg::DataWidth-1:0] pwdata,
   output logic      [lts_pkg::DataWidth-1:0] prdata,
   output logic                               pready,
   output lts_pkg::cfg_type                   cfg
);
   import lts_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign pready   = 1'b1;
   assign index    = reg_index_type'(paddr[AddrWidth-1:2]);
   assign write_en = psel && penable && pwrite && pready;

   // Update the addressed register on a completed write transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_BRIGHT_MARGIN: cfg_in.bright_margin = pwdata[SampleWidth-1:0];
            REG_TURN_STEP:     cfg_in.turn_step     = pwdata[StepWidth-1:0];
            REG_PULSE_MIN:     cfg_in.pulse_min     = pwdata[PulseWidth-1:0];
            REG_PULSE_MAX:     cfg_in.pulse_max     = pwdata[PulseWidth-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bright_margin <= MarginReset;
         cfg_ff.turn_step     <= StepReset;
         cfg_ff.pulse_min     <= PulseMinReset;
         cfg_ff.pulse_max     <= PulseMaxReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register, zero extended
   always_comb begin
      case (index)
         REG_BRIGHT_MARGIN: prdata = DataWidth'(cfg_ff.bright_margin);
         REG_TURN_STEP:     prdata = DataWidth'(cfg_ff.turn_step);
         REG_PULSE_MIN:     prdata = DataWidth'(cfg_ff.pulse_min);
         REG_PULSE_MAX:     prdata = DataWidth'(cfg_ff.pulse_max);
         default:           prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule : lts_csr

`default_nettype wire

@@ hdl/lts_decide.sv @@
// Combinational decision for one sample set: brightness tests, new level,
// requested turn and moved pulse. Depends on lts_pkg.
`default_nettype none

module lts_decide (
   input  lts_pkg::sample_type                   samples,
   input  lts_pkg::cfg_type                      cfg,
   input  wire logic [lts_pkg::SampleWidth-1:0]  level,
   input  wire logic [lts_pkg::PulseWidth-1:0]   pulse,
   output logic      [lts_pkg::SampleWidth-1:0]  level_next,
   output logic      [lts_pkg::PulseWidth-1:0]   pulse_next,
   output lts_pkg::turn_type                     turn
);
   import lts_pkg::*;

   logic                   all_bright;
   logic [SampleWidth-1:0] threshold;
   logic                   b_lt, b_lb, b_rt, b_rb;
   logic [11:0]            sum_all;
   logic [10:0]            sum_bottom, sum_top;
   logic [11:0]            sum_three;
   logic [23:0]            prod_three;
   logic                   may_move;
   logic [PulseWidth:0]    pulse_up;

   // Brightness tests against level minus margin
   assign all_bright = level < cfg.bright_margin;
   assign threshold  = all_bright ? '0 : level - cfg.bright_margin;
   assign b_lt = all_bright || (samples.left_top     < threshold);
   assign b_lb = all_bright || (samples.left_bottom  < threshold);
   assign b_rt = all_bright || (samples.right_top    < threshold);
   assign b_rb = all_bright || (samples.right_bottom < threshold);

   assign sum_all = 12'(samples.left_top) + 12'(samples.left_bottom)
                  + 12'(samples.right_top) + 12'(samples.right_bottom);
   assign sum_bottom = 11'(samples.left_bottom) + 11'(samples.right_bottom);
   assign sum_top    = 11'(samples.left_top) + 11'(samples.right_top);

   // Pick the turn and which three samples feed the new level
   always_comb begin
      turn      = TURN_NONE;
      sum_three = sum_all;
      if (level == '0 || !(b_lt || b_lb || b_rt || b_rb)) begin
         turn = TURN_NONE;
      end else if (b_lt && b_rt) begin
         turn = TURN_NONE;
      end else if (b_lb && b_rb) begin
         turn = TURN_NONE;
      end else if (b_lt || b_lb) begin
         turn      = TURN_LEFT;
         sum_three = sum_all - 12'(b_lt ? samples.left_top : samples.left_bottom);
      end else begin
         turn      = TURN_RIGHT;
         sum_three = sum_all - 12'(b_rt ? samples.right_top : samples.right_bottom);
      end
   end

   // Divide by three through the reciprocal
   assign prod_three = 24'(sum_three) * 24'(RecipThree);

   // Select the new level
   always_comb begin
      if (level == '0 || !(b_lt || b_lb || b_rt || b_rb)) begin
         level_next = sum_all[11:2];
      end else if (b_lt && b_rt) begin
         level_next = sum_bottom[10:1];
      end else if (b_lb && b_rb) begin
         level_next = sum_top[10:1];
      end else begin
         level_next = prod_three[RecipShift +: SampleWidth];
      end
   end

   // Move the pulse from inside the limits or away from the limit it sits on, saturating at zero and at PulseTop
   assign may_move = (pulse > cfg.pulse_min && pulse < cfg.pulse_max)
                  || (pulse == cfg.pulse_min && turn == TURN_LEFT)
                  || (pulse == cfg.pulse_max && turn == TURN_RIGHT);
   assign pulse_up = (PulseWidth+1)'(pulse) + (PulseWidth+1)'(cfg.turn_step);

   always_comb begin
      pulse_next = pulse;
      if (may_move) begin
         case (turn)
            TURN_LEFT:  pulse_next = pulse_up[PulseWidth] ? PulseTop
                                                          : pulse_up[PulseWidth-1:0];
            TURN_RIGHT: pulse_next = (pulse >= PulseWidth'(cfg.turn_step))
                                     ? pulse - PulseWidth'(cfg.turn_step) : '0;
            default:    pulse_next = pulse;
         endcase
      end
   end

endmodule : lts_decide

`default_nettype wire

@@ hdl/light_tracker_servo_step.sv @@
// Light tracker azimuth servo step. Each transfer on req_ brings four 10-bit
// sensor samples (lower is brighter); each yields one transfer on rsp_ with
// the requested turn (0 none, 1 left, 2 right), the azimuth pulse and the
// reference level after the step. An item is registered on accept, decided
// from the input register and lands in the result register once that is free
// or draining; one item per cycle is sustained while rsp_ready stays high:
// the reference level and pulse state registers are updated in the same
// cycle the result register loads, so the next item sees them right away.
// Configuration goes through the APB port: bright_margin at 0x0, turn_step
// at 0x4, pulse_min at 0x8 and pulse_max at 0xC. After reset the level is 0
// and the pulse 1600.
// Depends on lts_pkg, lts_csr and lts_decide.
`default_nettype none

module light_tracker_servo_step (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [lts_pkg::SampleWidth-1:0] req_left_top,
   input  wire logic [lts_pkg::SampleWidth-1:0] req_left_bottom,
   input  wire logic [lts_pkg::SampleWidth-1:0] req_right_top,
   input  wire logic [lts_pkg::SampleWidth-1:0] req_right_bottom,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [1:0]                      rsp_turn,
   output logic      [lts_pkg::PulseWidth-1:0]  rsp_azimuth_pulse,
   output logic      [lts_pkg::SampleWidth-1:0] rsp_reference_level,
   // configuration port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [lts_pkg::AddrWidth-1:0]   paddr,
   input  wire logic [lts_pkg::DataWidth-1:0]   pwdata,
   output logic      [lts_pkg::DataWidth-1:0]   prdata,
   output logic                                 pready
);
   import lts_pkg::*;

   cfg_type                cfg;
   // input stage
   logic                   in_valid_ff, in_valid_in;
   sample_type             in_ff, in_in;
   // tracker state
   logic [SampleWidth-1:0] level_ff, level_in;
   logic [PulseWidth-1:0]  pulse_ff, pulse_in;
   // result stage
   logic                   rsp_valid_ff, rsp_valid_in;
   turn_type               turn_ff, turn_in;
   // decision outputs
   logic [SampleWidth-1:0] level_next;
   logic [PulseWidth-1:0]  pulse_next;
   turn_type               turn_next;
   logic                   advance;
   logic                   req_take;

   lts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lts_decide u_decide (
      .samples    (in_ff),
      .cfg        (cfg),
      .level      (level_ff),
      .pulse      (pulse_ff),
      .level_next (level_next),
      .pulse_next (pulse_next),
      .turn       (turn_next)
   );

   // Advance the input stage when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   // Next values for input stage, state and result stage
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_in        = in_ff;
      level_in     = level_ff;
      pulse_in     = pulse_ff;
      rsp_valid_in = rsp_valid_ff;
      turn_in      = turn_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in  = 1'b0;
         level_in     = level_next;
         pulse_in     = pulse_next;
         turn_in      = turn_next;
         rsp_valid_in = 1'b1;
      end
      if (req_take) begin
         in_valid_in           = 1'b1;
         in_in.left_top        = req_left_top;
         in_in.left_bottom     = req_left_bottom;
         in_in.right_top       = req_right_top;
         in_in.right_bottom    = req_right_bottom;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         pulse_ff     <= PulseReset;
         turn_ff      <= TURN_NONE;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         pulse_ff     <= pulse_in;
         turn_ff      <= turn_in;
      end
      in_ff <= in_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_turn            = turn_ff;
   assign rsp_azimuth_pulse   = pulse_ff;
   assign rsp_reference_level = level_ff;

   // State only changes when an item moves into the result register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(level_ff) && $stable(pulse_ff)))
      else $error("tracker state changed without an item advancing");

   // No turn leaves the pulse where it was
   a_pulse_no_turn: assert property (@(posedge clock) disable iff (reset)
      (advance && turn_next == TURN_NONE) |=> $stable(pulse_ff))
      else $error("pulse moved on a step without a turn");

   // An advancing item always produces a result
   a_adv_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item produced no result");

   // An empty input stage never stalls the request side
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("request stalled with an empty input stage");

   // A stalled result keeps the input stage full
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_ready) |=> in_valid_ff)
      else $error("input stage dropped an item during a stall");

endmodule : light_tracker_servo_step

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for light_tracker_servo_step: sensor sample sets go in on req_,
// results are checked on rsp_ against an in-bench model of the level and pulse servo.
// Depends on lts_pkg and the light_tracker_servo_step RTL.
`timescale 1ns / 1ps

module testbench;
   import lts_pkg::*;

   // Expected result of one servo step
   typedef struct packed {
      turn_type               turn;
      logic [PulseWidth-1:0]  pulse;
      logic [SampleWidth-1:0] level;
   } servo_step_type;

   logic clock = 1'b0;
   logic reset;

   logic                   req_valid;
   logic                   req_ready;
   logic [SampleWidth-1:0] req_left_top;
   logic [SampleWidth-1:0] req_left_bottom;
   logic [SampleWidth-1:0] req_right_top;
   logic [SampleWidth-1:0] req_right_bottom;

   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [1:0]             rsp_turn;
   logic [PulseWidth-1:0]  rsp_azimuth_pulse;
   logic [SampleWidth-1:0] rsp_reference_level;

   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [AddrWidth-1:0]   paddr;
   logic [DataWidth-1:0]   pwdata;
   logic [DataWidth-1:0]   prdata;
   logic                   pready;

   // Tracker model state and register copies
   logic [SampleWidth-1:0] level_now;
   logic [PulseWidth-1:0]  pulse_now;
   logic [SampleWidth-1:0] margin_cfg;
   logic [StepWidth-1:0]   step_cfg;
   logic [PulseWidth-1:0]  min_cfg;
   logic [PulseWidth-1:0]  max_cfg;

   servo_step_type expected_steps[$];

   bit          idling_on = 1'b1;
   int unsigned rsp_hold_cycles = 0;
   int unsigned mismatches = 0;
   int unsigned items_sent = 0;
   int unsigned results_checked = 0;
   int unsigned left_turns = 0;
   int unsigned right_turns = 0;
   int unsigned csr_writes = 0;

   light_tracker_servo_step dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_left_top        (req_left_top),
      .req_left_bottom     (req_left_bottom),
      .req_right_top       (req_right_top),
      .req_right_bottom    (req_right_bottom),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_turn            (rsp_turn),
      .rsp_azimuth_pulse   (rsp_azimuth_pulse),
      .rsp_reference_level (rsp_reference_level),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always #5 clock = ~clock;

   // Advance the tracker model by one sample set and queue the result it implies
   task automatic predict_servo_step(input int unsigned lt, lb, rt, rb);
      int unsigned    thr;
      int unsigned    lvl;
      int unsigned    p;
      bit             all_bright;
      bit             b_lt, b_lb, b_rt, b_rb;
      bit             may_move;
      turn_type       dir;
      servo_step_type res;
      lvl        = 32'(level_now);
      dir        = TURN_NONE;
      all_bright = lvl < margin_cfg;
      thr        = all_bright ? 0 : lvl - margin_cfg;
      b_lt       = all_bright || lt < thr;
      b_lb       = all_bright || lb < thr;
      b_rt       = all_bright || rt < thr;
      b_rb       = all_bright || rb < thr;
      if (lvl == 0 || !(b_lt || b_lb || b_rt || b_rb)) begin
         lvl = (lt + lb + rt + rb) / 4;
      end else if (b_lt && b_rt) begin
         lvl = (lb + rb) / 2;
      end else if (b_lb && b_rb) begin
         lvl = (lt + rt) / 2;
      end else if (b_lt || b_lb) begin
         dir = TURN_LEFT;
         lvl = b_lt ? (lb + rt + rb) / 3 : (lt + rt + rb) / 3;
      end else begin
         dir = TURN_RIGHT;
         lvl = b_rt ? (lt + lb + rb) / 3 : (lt + lb + rt) / 3;
      end
      level_now = lvl[SampleWidth-1:0];
      // Move the pulse only from inside the limits or away from the limit it sits on
      p        = 32'(pulse_now);
      may_move = (p > min_cfg && p < max_cfg) ||
                 (p == min_cfg && dir == TURN_LEFT) ||
                 (p == max_cfg && dir == TURN_RIGHT);
      if (dir != TURN_NONE && may_move) begin
         if (dir == TURN_LEFT) begin
            p = (p + step_cfg > PulseTop) ? 32'(PulseTop) : p + step_cfg;
         end else begin
            p = (p >= step_cfg) ? p - step_cfg : 0;
         end
      end
      pulse_now = p[PulseWidth-1:0];
      res.turn  = dir;
      res.pulse = pulse_now;
      res.level = level_now;
      expected_steps.push_back(res);
   endtask

   // Offer one sample set after a random gap and hold it until the transfer
   task automatic send_sensor_item(input int unsigned lt, lb, rt, rb);
      int unsigned gap;
      gap = idling_on ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_left_top     <= lt[SampleWidth-1:0];
      req_left_bottom  <= lb[SampleWidth-1:0];
      req_right_top    <= rt[SampleWidth-1:0];
      req_right_bottom <= rb[SampleWidth-1:0];
      do @(posedge clock); while (!req_ready);
      predict_servo_step(lt, lb, rt, rb);
      items_sent++;
   endtask

   // One sensor dark-free (0) against a fully dark rest, which keeps the level at 1023
   task automatic send_turn(input turn_type dir, input bit on_top);
      if (dir == TURN_LEFT) begin
         send_sensor_item(on_top ? 0 : 1023, on_top ? 1023 : 0, 1023, 1023);
      end else begin
         send_sensor_item(1023, 1023, on_top ? 0 : 1023, on_top ? 1023 : 0);
      end
   endtask

   // Mostly sets shaped around the current threshold, the rest fully random
   task automatic send_random_sensor_item;
      int unsigned thr;
      int unsigned mode;
      int unsigned pick;
      int unsigned s[4];
      bit          bright;
      thr  = (level_now < margin_cfg) ? 0 : 32'(level_now - margin_cfg);
      mode = $urandom_range(0, 9);
      pick = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) begin
         bright = (mode < 7) ? (i == pick) : $urandom_range(0, 1);
         if (mode < 3 || thr == 0) begin
            s[i] = $urandom_range(0, 1023);
         end else begin
            s[i] = bright ? $urandom_range(0, thr - 1) : $urandom_range(thr, 1023);
         end
      end
      send_sensor_item(s[0], s[1], s[2], s[3]);
   endtask

   // Drop valid and hold until every queued result has come back
   task automatic wait_results_done;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_steps.size() != 0) @(posedge clock);
   endtask

   // Write one register, update the model copy, then read it back
   task automatic csr_write(input reg_index_type idx, input int unsigned value);
      logic [DataWidth-1:0] want_rd;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_BRIGHT_MARGIN: begin
            margin_cfg = value[SampleWidth-1:0];
            want_rd    = DataWidth'(margin_cfg);
         end
         REG_TURN_STEP: begin
            step_cfg = value[StepWidth-1:0];
            want_rd  = DataWidth'(step_cfg);
         end
         REG_PULSE_MIN: begin
            min_cfg = value[PulseWidth-1:0];
            want_rd = DataWidth'(min_cfg);
         end
         default: begin
            max_cfg = value[PulseWidth-1:0];
            want_rd = DataWidth'(max_cfg);
         end
      endcase
      csr_writes++;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want_rd) begin
         $display("%0t: register %s read back, expected %0d, actual %0d",
                  $time, idx.name(), want_rd, prdata);
         mismatches++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Every decision branch with the reset configuration
   task automatic test_directed_decisions;
      send_sensor_item(0, 0, 0, 0);             // level zero, all-dark-free samples
      send_sensor_item(1023, 1023, 1023, 1023); // level zero again, full scale
      send_sensor_item(0, 1023, 1023, 1023);    // left via left-top
      send_sensor_item(1023, 0, 1023, 1023);    // left via left-bottom
      send_sensor_item(1023, 1023, 0, 1023);    // right via right-top
      send_sensor_item(1023, 1023, 1023, 0);    // right via right-bottom
      send_sensor_item(0, 1023, 0, 1023);       // both tops brighter
      send_sensor_item(1023, 0, 1023, 0);       // both bottoms brighter
      send_sensor_item(0, 0, 1023, 1023);       // both left, left-top wins
      send_sensor_item(700, 700, 700, 700);     // nothing brighter
      send_sensor_item(50, 50, 50, 50);         // everything brighter, level lands on margin
      send_sensor_item(0, 0, 0, 0);             // level equal to margin: threshold zero
      send_sensor_item(40, 40, 40, 40);         // level zero, set to 40
      send_sensor_item(1023, 1023, 1023, 1023); // level below margin: all brighter
      send_sensor_item(1023, 1023, 0, 0);       // both right, right-top wins
      send_sensor_item(1023, 0, 0, 1023);       // left-bottom with right-top
      send_sensor_item(0, 1023, 1023, 0);       // left-top with right-bottom
      wait_results_done();
   endtask

   // Pulse at and between the limits, zero step and crossed limits
   task automatic test_pulse_limits;
      int unsigned base;
      base = 32'(pulse_now);
      csr_write(REG_BRIGHT_MARGIN, 100);
      csr_write(REG_TURN_STEP, 25);
      csr_write(REG_PULSE_MIN, base);
      csr_write(REG_PULSE_MAX, base + 50);
      send_sensor_item(1023, 1023, 1023, 1023);
      // climb off the lower limit, reach the upper one and hold there
      for (int n = 0; n < 4; n++) send_turn(TURN_LEFT, n[0]);
      // come back down and hold at the lower limit
      for (int n = 0; n < 4; n++) send_turn(TURN_RIGHT, n[0]);
      wait_results_done();
      csr_write(REG_TURN_STEP, 0);
      send_turn(TURN_LEFT, 1'b1);
      send_turn(TURN_RIGHT, 1'b0);
      wait_results_done();
      // minimum above maximum
      csr_write(REG_TURN_STEP, 25);
      csr_write(REG_PULSE_MIN, 32'(pulse_now));
      csr_write(REG_PULSE_MAX, 32'(pulse_now) - 100);
      send_turn(TURN_LEFT, 1'b0);
      send_turn(TURN_LEFT, 1'b1);
      send_turn(TURN_RIGHT, 1'b1);
      wait_results_done();
   endtask

   // Drive the pulse into zero and into the 15-bit ceiling
   task automatic test_pulse_saturation;
      csr_write(REG_BRIGHT_MARGIN, 50);
      csr_write(REG_TURN_STEP, 500);
      csr_write(REG_PULSE_MIN, 0);
      csr_write(REG_PULSE_MAX, 32'(PulseTop));
      send_sensor_item(1023, 1023, 1023, 1023);
      while (pulse_now != 0) send_turn(TURN_RIGHT, $urandom_range(0, 1));
      send_turn(TURN_RIGHT, 1'b1);
      wait_results_done();
      csr_write(REG_TURN_STEP, 511);
      while (pulse_now != PulseTop) send_turn(TURN_LEFT, $urandom_range(0, 1));
      send_turn(TURN_LEFT, 1'b0);
      wait_results_done();
   endtask

   // Receiver holds off while the sender streams, so the block backs up
   task automatic test_result_backpressure;
      idling_on       = 1'b0;
      rsp_hold_cycles = 80;
      for (int n = 0; n < 40; n++) send_random_sensor_item();
      wait_results_done();
      idling_on = 1'b1;
   endtask

   // Random phases, each with its own configuration
   task automatic test_random_phases;
      int unsigned lo;
      int unsigned hi;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       csr_write(REG_BRIGHT_MARGIN, 0);
            1:       csr_write(REG_BRIGHT_MARGIN, 1023);
            default: csr_write(REG_BRIGHT_MARGIN, $urandom_range(0, 200));
         endcase
         case (phase)
            3:       csr_write(REG_TURN_STEP, 1);
            4:       csr_write(REG_TURN_STEP, 500);
            default: csr_write(REG_TURN_STEP, $urandom_range(1, 500));
         endcase
         // keep the pulse inside the window so it keeps moving
         if (pulse_now <= 19500) begin
            lo = $urandom_range(0, 32'(pulse_now));
            hi = $urandom_range(32'(pulse_now), 19500);
         end else begin
            lo = $urandom_range(0, 19500);
            hi = 32'(PulseTop);
         end
         csr_write(REG_PULSE_MIN, lo);
         csr_write(REG_PULSE_MAX, hi);
         idling_on = (phase != 2);
         for (int n = 0; n < 190; n++) begin
            send_random_sensor_item();
            if ($urandom_range(0, 99) == 0) wait_results_done();
         end
         wait_results_done();
      end
      idling_on = 1'b1;
   endtask

   // Result receiver: random stalls per transfer plus any requested hold-off
   initial begin
      int unsigned wait_cycles;
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         wait_cycles     = rsp_hold_cycles + (idling_on ? $urandom_range(0, 5) : 0);
         rsp_hold_cycles = 0;
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare each result transfer with the oldest expected step
   always @(posedge clock) begin
      servo_step_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_steps.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual turn %0d pulse %0d level %0d",
                     $time, rsp_turn, rsp_azimuth_pulse, rsp_reference_level);
            mismatches++;
         end else begin
            want = expected_steps.pop_front();
            results_checked++;
            if (want.turn == TURN_LEFT) left_turns++;
            if (want.turn == TURN_RIGHT) right_turns++;
            if (rsp_turn !== want.turn) begin
               $display("%0t: turn, expected %0d, actual %0d", $time, want.turn, rsp_turn);
               mismatches++;
            end
            if (rsp_azimuth_pulse !== want.pulse) begin
               $display("%0t: azimuth_pulse, expected %0d, actual %0d",
                        $time, want.pulse, rsp_azimuth_pulse);
               mismatches++;
            end
            if (rsp_reference_level !== want.level) begin
               $display("%0t: reference_level, expected %0d, actual %0d",
                        $time, want.level, rsp_reference_level);
               mismatches++;
            end
         end
      end
   end

   // Hard stop for a hung run
   initial begin
      #5000000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_left_top     = '0;
      req_left_bottom  = '0;
      req_right_top    = '0;
      req_right_bottom = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      level_now        = '0;
      pulse_now        = PulseReset;
      margin_cfg       = MarginReset;
      step_cfg         = StepReset;
      min_cfg          = PulseMinReset;
      max_cfg          = PulseMaxReset;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_decisions();
      test_pulse_limits();
      test_pulse_saturation();
      test_result_backpressure();
      test_random_phases();

      wait_results_done();
      repeat (10) @(posedge clock);
      $display("Ran %0d sample sets, %0d results checked (%0d left, %0d right turns)",
               items_sent, results_checked, left_turns, right_turns);
      $display("over %0d register writes: decisions, pulse limits, saturation, stalls, random",
               csr_writes);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/lts_pkg.sv
hdl/lts_csr.sv
hdl/lts_decide.sv
hdl/light_tracker_servo_step.sv
dv/testbench.sv
